/* rtl/tjdz_pkg.sv */
// ----------------------------------------------------------------------------
// tjdz_pkg
// Shared types and constants of the touch joystick dead zone block.
// ----------------------------------------------------------------------------
package tjdz_pkg;

  localparam int CoordBits = 12;
  localparam int SubW      = 40;

  // register indexes of the configuration port
  localparam logic [2:0] REG_ROTATION  = 3'd0;
  localparam logic [2:0] REG_SCREEN_W  = 3'd1;
  localparam logic [2:0] REG_SCREEN_H  = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_DEAD_FRAC = 3'd4;
  localparam logic [2:0] REG_ZONE_MIN  = 3'd5;
  localparam logic [2:0] REG_ZONE_MAX  = 3'd6;
  localparam logic [2:0] REG_DIR_DEAD  = 3'd7;

  // rotation modes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  // direction codes
  localparam logic [3:0] DIR_NONE = 4'd0;
  localparam logic [3:0] DIR_W    = 4'd1;
  localparam logic [3:0] DIR_S    = 4'd2;
  localparam logic [3:0] DIR_A    = 4'd3;
  localparam logic [3:0] DIR_D    = 4'd4;
  localparam logic [3:0] DIR_WA   = 4'd5;
  localparam logic [3:0] DIR_WD   = 4'd6;
  localparam logic [3:0] DIR_SA   = 4'd7;
  localparam logic [3:0] DIR_SD   = 4'd8;

  localparam logic [7:0] DeadFracMax = 8'd230;

  typedef struct packed {
    logic [CoordBits-1:0] touch_x;
    logic [CoordBits-1:0] touch_y;
    logic                 finger_down;
    logic                 press_edge;
    logic                 release_edge;
    logic                 capture_granted;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic               stick_active;
    logic [3:0]         direction_code;
    logic               release_owner;
  } out_item_t;

  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            ge;
  } csub_res_t;

endpackage

/* rtl/tjdz_if.sv */
// ----------------------------------------------------------------------------
// tjdz_if
// Valid/ready channels for touch frames and stick results.
// ----------------------------------------------------------------------------
interface tjdz_in_if;
  logic               valid;
  logic               ready;
  tjdz_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tjdz_out_if;
  logic                valid;
  logic                ready;
  tjdz_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tjdz_csub.sv */
// ----------------------------------------------------------------------------
// tjdz_csub
// Shared compare-and-subtract unit for the square root and the dividers.
// ----------------------------------------------------------------------------
module tjdz_csub import tjdz_pkg::*; (
  input  logic [SubW-1:0] a_i,
  input  logic [SubW-1:0] b_i,
  output csub_res_t       res_o
);

  logic [SubW:0] diff;

  assign diff        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff  = diff[SubW-1:0];
  assign res_o.ge    = ~diff[SubW];

endmodule

/* rtl/touch_joystick_dead_zone.sv */
// ----------------------------------------------------------------------------
// touch_joystick_dead_zone
// Touch joystick with a scaled radial dead zone, one touch frame per item.
// ----------------------------------------------------------------------------
// When no stick value is computed, a frame goes straight to the final state;
// when the held finger falls inside the dead zone, the frame ends after the
// square root. The full stick value takes a 22-step square root, a 16-step
// division for the usable magnitude and two 17-step divisions for the
// components, all on one shared compare-and-subtract unit, plus one shared
// 16x16 multiplier. The input is ready only while the sequencer is idle; a
// finished result waits in the output register while the next frame is taken.
// Configuration is written through cfg_we_i/cfg_index_i.
module touch_joystick_dead_zone import tjdz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  tjdz_in_if.sink     in_i,
  tjdz_out_if.source  out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQRT, S_USE, S_DIVU,
    S_MULX, S_DIVX, S_MULY, S_DIVY, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [1:0]  rot_q;
  logic [11:0] scr_w_q, scr_h_q;
  logic [10:0] radius_q;
  logic [7:0]  dzf_q;
  logic [23:0] zmin_q, zmax_q;
  logic [14:0] ddead_q;

  // stick state
  logic               active_q;
  logic signed [12:0] cx_q, cy_q;
  logic signed [15:0] vx_q, vy_q;

  // per-item work registers
  logic signed [12:0] tx_q, ty_q;
  logic               rel_q;
  logic signed [13:0] dx_q, dy_q;
  logic [18:0]        dz_q;
  logic [27:0]        len2_q;
  logic [43:0]        rad_q;
  logic [SubW-1:0]    p_q, b_q;
  logic [21:0]        root_q, len_q;
  logic [15:0]        usable_q;
  logic [4:0]         cnt_q;

  out_item_t out_q;
  logic      out_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q    <= ROT_NONE;
      scr_w_q  <= 12'd1920;
      scr_h_q  <= 12'd1080;
      radius_q <= 11'd100;
      dzf_q    <= 8'd26;
      zmin_q   <= 24'd0;
      zmax_q   <= 24'hFFFFFF;
      ddead_q  <= 15'd9830;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROTATION:  rot_q    <= cfg_data_i[1:0];
        REG_SCREEN_W:  scr_w_q  <= cfg_data_i[11:0];
        REG_SCREEN_H:  scr_h_q  <= cfg_data_i[11:0];
        REG_RADIUS:    radius_q <= cfg_data_i[10:0];
        REG_DEAD_FRAC: dzf_q    <= cfg_data_i[7:0];
        REG_ZONE_MIN:  zmin_q   <= cfg_data_i;
        REG_ZONE_MAX:  zmax_q   <= cfg_data_i;
        REG_DIR_DEAD:  ddead_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // rotation to screen space
  logic signed [12:0] tx_c, ty_c;
  always_comb begin
    tx_c = $signed({1'b0, in_i.data.touch_x});
    ty_c = $signed({1'b0, in_i.data.touch_y});
    case (rot_q)
      ROT_CW: begin
        tx_c = $signed({1'b0, scr_h_q} - {1'b0, in_i.data.touch_y});
        ty_c = $signed({1'b0, in_i.data.touch_x});
      end
      ROT_CCW: begin
        tx_c = $signed({1'b0, in_i.data.touch_y});
        ty_c = $signed({1'b0, scr_w_q} - {1'b0, in_i.data.touch_x});
      end
      default: ;
    endcase
  end

  logic in_zone;
  assign in_zone = (tx_c >= $signed({1'b0, zmin_q[23:12]})) &&
                   (tx_c <= $signed({1'b0, zmax_q[23:12]})) &&
                   (ty_c >= $signed({1'b0, zmin_q[11:0]})) &&
                   (ty_c <= $signed({1'b0, zmax_q[11:0]}));

  logic active_n;
  always_comb begin
    active_n = active_q;
    if (in_i.data.press_edge) begin
      if (!in_zone) active_n = 1'b0;
      else if (in_i.data.capture_granted) active_n = 1'b1;
    end
  end

  logic [10:0] r_eff;
  logic [7:0]  frac_eff;
  assign r_eff    = (radius_q == 11'd0) ? 11'd1 : radius_q;
  assign frac_eff = (dzf_q > DeadFracMax) ? DeadFracMax : dzf_q;

  logic [13:0] abs_dx, abs_dy;
  assign abs_dx = dx_q[13] ? 14'(-dx_q) : 14'(dx_q);
  assign abs_dy = dy_q[13] ? 14'(-dy_q) : 14'(dy_q);

  // shared multiplier
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DIFF: begin mul_a = {8'd0, frac_eff}; mul_b = {5'd0, r_eff}; end
      S_SQX:  begin mul_a = {2'd0, abs_dx};   mul_b = {2'd0, abs_dx}; end
      S_SQY:  begin mul_a = {2'd0, abs_dy};   mul_b = {2'd0, abs_dy}; end
      S_MULX: begin mul_a = {2'd0, abs_dy};   mul_b = usable_q; end
      S_MULY: begin mul_a = {2'd0, abs_dx};   mul_b = usable_q; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [27:0] len2_sum;
  assign len2_sum = len2_q + mul_p[27:0];

  // shared compare-and-subtract unit
  logic [SubW-1:0] sub_a, sub_b;
  csub_res_t       sub_res;
  always_comb begin
    if (state_q == S_SQRT) begin
      sub_a = {p_q[SubW-3:0], rad_q[43:42]};
      sub_b = {16'd0, root_q, 2'b01};
    end else begin
      sub_a = p_q;
      sub_b = b_q;
    end
  end

  tjdz_csub u_csub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  logic [SubW-1:0] p_step;
  logic [21:0]     root_next;
  assign p_step    = sub_res.ge ? sub_res.diff : sub_a;
  assign root_next = {root_q[20:0], sub_res.ge};

  // magnitude setup
  logic [18:0]     rq8, den;
  logic [21:0]     clamped, excess;
  logic            in_dead;
  logic [SubW-1:0] num_u;
  assign rq8     = {r_eff, 8'd0};
  assign den     = rq8 - dz_q;
  assign in_dead = (len2_q == 28'd0) || (len_q <= {3'd0, dz_q});
  assign clamped = (len_q > {3'd0, rq8}) ? {3'd0, rq8} : len_q;
  assign excess  = clamped - {3'd0, dz_q};
  assign num_u   = {3'd0, excess, 15'd0} + {21'd0, den[18:1]};

  logic [SubW-1:0] num_c;
  assign num_c = {3'd0, mul_p[28:0], 8'd0} + {19'd0, len_q[21:1]};

  function automatic logic signed [15:0] sat_comp(input logic [21:0] q, input logic neg);
    logic signed [15:0] r;
    if (neg) r = (q > 22'd32768) ? -16'sd32768 : 16'(-q);
    else r = (q > 22'd32767) ? 16'sd32767 : 16'(q);
    return r;
  endfunction

  // final direction code
  logic signed [15:0] fvx, fvy, dead_p, dead_n;
  logic [3:0]         code;
  assign fvx    = rel_q ? 16'sd0 : vx_q;
  assign fvy    = rel_q ? 16'sd0 : vy_q;
  assign dead_p = $signed({1'b0, ddead_q});
  assign dead_n = -dead_p;
  always_comb begin
    code = DIR_NONE;
    if (fvy > dead_p) code = DIR_W;
    else if (fvy < dead_n) code = DIR_S;
    if (fvx < dead_n) begin
      code = (code == DIR_NONE) ? DIR_A : ((code == DIR_W) ? DIR_WA : DIR_SA);
    end else if (fvx > dead_p) begin
      code = (code == DIR_NONE) ? DIR_D : ((code == DIR_W) ? DIR_WD : DIR_SD);
    end
  end

  logic in_fire, out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            tx_q     <= tx_c;
            ty_q     <= ty_c;
            rel_q    <= in_i.data.release_edge;
            active_q <= active_n;
            if (in_i.data.press_edge && in_zone && in_i.data.capture_granted) begin
              cx_q <= tx_c;
              cy_q <= ty_c;
            end
            state_q <= (in_i.data.finger_down && active_n) ? S_DIFF : S_FIN;
          end
        end
        S_DIFF: begin
          dx_q    <= {tx_q[12], tx_q} - {cx_q[12], cx_q};
          dy_q    <= {ty_q[12], ty_q} - {cy_q[12], cy_q};
          dz_q    <= mul_p[18:0];
          state_q <= S_SQX;
        end
        S_SQX: begin
          len2_q  <= mul_p[27:0];
          state_q <= S_SQY;
        end
        S_SQY: begin
          len2_q  <= len2_sum;
          rad_q   <= {len2_sum, 16'd0};
          p_q     <= '0;
          root_q  <= '0;
          cnt_q   <= 5'd21;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          p_q    <= p_step;
          root_q <= root_next;
          rad_q  <= {rad_q[41:0], 2'b00};
          if (cnt_q == 5'd0) begin
            len_q   <= root_next;
            state_q <= S_USE;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_USE: begin
          if (in_dead) begin
            vx_q    <= '0;
            vy_q    <= '0;
            state_q <= S_FIN;
          end else begin
            p_q     <= num_u;
            b_q     <= {6'd0, den, 15'd0};
            root_q  <= '0;
            cnt_q   <= 5'd15;
            state_q <= S_DIVU;
          end
        end
        S_DIVU, S_DIVX, S_DIVY: begin
          p_q    <= p_step;
          root_q <= root_next;
          b_q    <= {1'b0, b_q[SubW-1:1]};
          if (cnt_q == 5'd0) begin
            if (state_q == S_DIVU) begin
              usable_q <= root_next[15:0];
              state_q  <= S_MULX;
            end else if (state_q == S_DIVX) begin
              vx_q    <= sat_comp(root_next, dy_q[13]);
              state_q <= S_MULY;
            end else begin
              vy_q    <= sat_comp(root_next, dx_q[13]);
              state_q <= S_FIN;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_MULX, S_MULY: begin
          p_q     <= num_c;
          b_q     <= {2'd0, len_q, 16'd0};
          root_q  <= '0;
          cnt_q   <= 5'd16;
          state_q <= (state_q == S_MULX) ? S_DIVX : S_DIVY;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            if (rel_q) begin
              active_q <= 1'b0;
              vx_q     <= '0;
              vy_q     <= '0;
            end
            out_q.stick_x        <= fvx;
            out_q.stick_y        <= fvy;
            out_q.stick_active   <= active_q && !rel_q;
            out_q.direction_code <= code;
            out_q.release_owner  <= rel_q && active_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // a release can never leave the stick active
  a_release_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.release_owner |-> !out_q.stick_active)
    else $error("release_owner with stick still active");

  // only legal direction codes leave the block
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.direction_code <= DIR_SD)
    else $error("direction code out of range");

  // an item is taken only while the sequencer is idle, which it leaves after every item
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("sequencer did not leave idle after an item");

  // a result is loaded only from the final state
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("output loaded outside the final state");

endmodule
